// File: hw/rtl/kcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kcm_pkg;

   // field widths
   localparam int OP_W     = 1;
   localparam int DEV_W    = 2;
   localparam int ETYPE_W  = 5;
   localparam int KEY_W    = 10;
   localparam int KVAL_W   = 2;
   localparam int ENTRY_W  = 4;
   localparam int POS_W    = 2;
   localparam int CLIENT_W = 3;
   localparam int TAG_W    = 16;

   // parameter defaults
   localparam int CHORD_KEYS_DEF   = 4;
   localparam int BIND_ENTRIES_DEF = 16;
   localparam int KEYBOARDS_DEF    = 4;

   // result limit per event
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   // codes
   localparam logic [OP_W-1:0]    OP_EVENT   = 1'b0;
   localparam logic [OP_W-1:0]    OP_BIND    = 1'b1;
   localparam logic [ETYPE_W-1:0] EV_KEY     = 5'd1;
   localparam logic [KVAL_W-1:0]  KV_RELEASE = 2'd0;
   localparam logic [KVAL_W-1:0]  KV_PRESS   = 2'd1;
   localparam logic [KEY_W-1:0]   KEY_EMPTY  = '0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SCAN,
      ST_FLUSH
   } kcm_state_type;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [DEV_W-1:0]    device_id;
      logic [ETYPE_W-1:0]  event_type;
      logic [KEY_W-1:0]    key_code;
      logic [KVAL_W-1:0]   key_value;
      logic [ENTRY_W-1:0]  bind_entry;
      logic [POS_W-1:0]    bind_pos;
      logic [CLIENT_W-1:0] bind_client;
      logic [TAG_W-1:0]    bind_tag_in;
      logic                bind_enable;
   } kcm_req_type;

   // binding write broadcast to every cell
   typedef struct packed {
      logic                en;
      logic [ENTRY_W-1:0]  entry;
      logic [POS_W-1:0]    pos;
      logic [KEY_W-1:0]    key;
      logic [CLIENT_W-1:0] client;
      logic [TAG_W-1:0]    tag;
      logic                enable;
   } bwr_type;

endpackage

`default_nettype wire

// File: hw/rtl/kcm_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface kcm_req_if;
   logic                          valid;
   logic                          ready;
   logic [kcm_pkg::OP_W-1:0]      op;
   logic [kcm_pkg::DEV_W-1:0]     device_id;
   logic [kcm_pkg::ETYPE_W-1:0]   event_type;
   logic [kcm_pkg::KEY_W-1:0]     key_code;
   logic [kcm_pkg::KVAL_W-1:0]    key_value;
   logic [kcm_pkg::ENTRY_W-1:0]   bind_entry;
   logic [kcm_pkg::POS_W-1:0]     bind_pos;
   logic [kcm_pkg::CLIENT_W-1:0]  bind_client;
   logic [kcm_pkg::TAG_W-1:0]     bind_tag_in;
   logic                          bind_enable;

   modport source (
      output valid, op, device_id, event_type, key_code, key_value,
             bind_entry, bind_pos, bind_client, bind_tag_in, bind_enable,
      input  ready
   );

   modport sink (
      input  valid, op, device_id, event_type, key_code, key_value,
             bind_entry, bind_pos, bind_client, bind_tag_in, bind_enable,
      output ready
   );
endinterface

interface kcm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [kcm_pkg::CLIENT_W-1:0]  client_id;
   logic [kcm_pkg::TAG_W-1:0]     bind_tag;
   logic                          last;

   modport source (
      output valid, client_id, bind_tag, last,
      input  ready
   );

   modport sink (
      input  valid, client_id, bind_tag, last,
      output ready
   );
endinterface

`default_nettype wire

// File: hw/rtl/key_chord_matcher.sv
`timescale 1ns / 1ps
`default_nettype none

// Hotkey chord detector.
// req_ch carries one item per transfer: op 1 writes one key slot of a binding
// entry (plus its owner, tag and enable), op 0 is a keyboard event. Only key
// events (type 1) with value release or press act; the rest, and a press of a
// held key, are dropped. Each other key event updates that keyboard's held-key
// row, then a scan token walks the chain of binding cells, one cell per cycle.
// Each matching valid entry yields one rsp_ch transfer {client_id, bind_tag},
// in entry order, at most MAX_RESULTS of them; last marks the final one of the
// event. A binding write or dropped event returns to idle straight after
// evaluation; a scanned event holds req_ch through the cell walk and the flush.
// One result is held back so that last can be set; the output register frees
// req_ch while the final result waits to be taken. When rsp_ch stalls and a
// new hit finds the held-back result still waiting, the token stops in place
// and resumes on the next transfer. Reset empties every held-key slot and
// invalidates all bindings; binding keys, owners and tags must be written
// before an entry is enabled.
module key_chord_matcher #(
   parameter int CHORD_KEYS   = kcm_pkg::CHORD_KEYS_DEF,
   parameter int BIND_ENTRIES = kcm_pkg::BIND_ENTRIES_DEF,
   parameter int KEYBOARDS    = kcm_pkg::KEYBOARDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   kcm_req_if.sink     req_ch,
   kcm_rsp_if.source   rsp_ch
);
   import kcm_pkg::*;

   localparam int KBW = (KEYBOARDS > 1) ? $clog2(KEYBOARDS) : 1;
   localparam int SW  = (CHORD_KEYS > 1) ? $clog2(CHORD_KEYS) : 1;

   typedef logic [CHORD_KEYS-1:0][KEY_W-1:0] row_type;

   kcm_state_type        state_ff, state_in;
   kcm_req_type          q_ff;
   row_type              held_ff [KEYBOARDS];
   row_type              row;
   row_type              row_in;
   logic                 ev_ok;
   logic                 do_scan;
   logic                 held_we;
   logic [KBW-1:0]       dev_idx;

   logic                 advance;
   logic                 start;
   logic                 take;
   logic                 hit_any;
   logic                 out_free;
   logic                 out_load;
   logic                 out_last;
   logic                 pend_clear;
   bwr_type              wr;

   logic [CNT_W-1:0]     cnt_ff;
   logic                 pend_vld_ff;
   logic [CLIENT_W-1:0]  pend_client_ff;
   logic [TAG_W-1:0]     pend_tag_ff;
   logic                 rsp_vld_ff;
   logic [CLIENT_W-1:0]  rsp_client_ff;
   logic [TAG_W-1:0]     rsp_tag_ff;
   logic                 rsp_last_ff;

   logic [BIND_ENTRIES-1:0]  tok_w;
   logic [BIND_ENTRIES-1:0]  hit_w;
   row_type                  held_w  [BIND_ENTRIES];
   logic [CLIENT_W-1:0]      owner_w [BIND_ENTRIES];
   logic [TAG_W-1:0]         tag_w   [BIND_ENTRIES];
   logic [CLIENT_W-1:0]      hit_client;
   logic [TAG_W-1:0]         hit_tag;

   // ---------------- request capture ----------------
   assign req_ch.ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         q_ff.op          <= req_ch.op;
         q_ff.device_id   <= req_ch.device_id;
         q_ff.event_type  <= req_ch.event_type;
         q_ff.key_code    <= req_ch.key_code;
         q_ff.key_value   <= req_ch.key_value;
         q_ff.bind_entry  <= req_ch.bind_entry;
         q_ff.bind_pos    <= req_ch.bind_pos;
         q_ff.bind_client <= req_ch.bind_client;
         q_ff.bind_tag_in <= req_ch.bind_tag_in;
         q_ff.bind_enable <= req_ch.bind_enable;
      end
   end

   // ---------------- held-key update ----------------
   assign dev_idx = KBW'(q_ff.device_id);
   assign row     = held_ff[dev_idx];

   always_comb begin
      logic           found, zfound;
      logic [SW-1:0]  fidx, zidx;
      found  = 1'b0;
      zfound = 1'b0;
      fidx   = '0;
      zidx   = '0;
      // walk downward so the lowest matching slot wins
      for (int i = CHORD_KEYS - 1; i >= 0; i--) begin
         if (row[i] == q_ff.key_code) begin
            found = 1'b1;
            fidx  = SW'(i);
         end
         if (row[i] == KEY_EMPTY) begin
            zfound = 1'b1;
            zidx   = SW'(i);
         end
      end
      ev_ok = (q_ff.op == OP_EVENT) && (int'(q_ff.device_id) < KEYBOARDS)
           && (q_ff.event_type == EV_KEY)
           && ((q_ff.key_value == KV_RELEASE) || (q_ff.key_value == KV_PRESS));
      row_in = row;
      if (q_ff.key_value == KV_RELEASE) begin
         if (found) begin
            row_in[fidx] = KEY_EMPTY;
         end
      end else if (!found && zfound) begin
         row_in[zidx] = q_ff.key_code;
      end
      do_scan = ev_ok && !((q_ff.key_value == KV_PRESS) && found);
   end

   assign held_we = (state_ff == ST_EVAL) && do_scan;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KEYBOARDS; k++) begin
            held_ff[k] <= '0;
         end
      end else if (held_we) begin
         held_ff[dev_idx] <= row_in;
      end
   end

   // ---------------- binding write ----------------
   always_comb begin
      wr.en     = (state_ff == ST_EVAL) && (q_ff.op == OP_BIND)
               && (int'(q_ff.bind_pos) < CHORD_KEYS);
      wr.entry  = q_ff.bind_entry;
      wr.pos    = q_ff.bind_pos;
      wr.key    = q_ff.key_code;
      wr.client = q_ff.bind_client;
      wr.tag    = q_ff.bind_tag_in;
      wr.enable = q_ff.bind_enable;
   end

   // ---------------- cell chain ----------------
   for (genvar g = 0; g < BIND_ENTRIES; g++) begin : g_cell
      logic     tok_i;
      row_type  held_i;
      if (g == 0) begin : g_head
         assign tok_i  = start;
         assign held_i = row_in;
      end else begin : g_body
         assign tok_i  = tok_w[g-1];
         assign held_i = held_w[g-1];
      end

      kcm_cell #(
         .CHORD_KEYS (CHORD_KEYS),
         .IDX        (g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tok_i   (tok_i),
         .held_i  (held_i),
         .wr      (wr),
         .tok_o   (tok_w[g]),
         .held_o  (held_w[g]),
         .hit_o   (hit_w[g]),
         .owner_o (owner_w[g]),
         .tag_o   (tag_w[g])
      );
   end

   // at most one cell holds the token, so an OR picks its result
   always_comb begin
      hit_client = '0;
      hit_tag    = '0;
      for (int e = 0; e < BIND_ENTRIES; e++) begin
         hit_client = hit_client | owner_w[e];
         hit_tag    = hit_tag | tag_w[e];
      end
   end

   assign hit_any  = |hit_w;
   assign out_free = !rsp_vld_ff || rsp_ch.ready;

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      advance    = 1'b1;
      start      = 1'b0;
      take       = 1'b0;
      out_load   = 1'b0;
      out_last   = 1'b0;
      pend_clear = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (do_scan) begin
               start    = 1'b1;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            take = hit_any && (cnt_ff < CNT_W'(MAX_RESULTS));
            // hold the chain while a new hit cannot push the pending one out
            if (take && pend_vld_ff && !out_free) begin
               advance = 1'b0;
               take    = 1'b0;
            end
            if (advance) begin
               out_load = take && pend_vld_ff;
               if (tok_w[BIND_ENTRIES-1]) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_vld_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_load   = 1'b1;
               out_last   = 1'b1;
               pend_clear = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------- pending result and count ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
         cnt_ff      <= '0;
      end else if (state_ff == ST_EVAL) begin
         pend_vld_ff <= 1'b0;
         cnt_ff      <= '0;
      end else if (take) begin
         pend_vld_ff <= 1'b1;
         cnt_ff      <= cnt_ff + CNT_W'(1);
      end else if (pend_clear) begin
         pend_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pend_client_ff <= hit_client;
         pend_tag_ff    <= hit_tag;
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_load) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_client_ff <= pend_client_ff;
         rsp_tag_ff    <= pend_tag_ff;
         rsp_last_ff   <= out_last;
      end
   end

   assign rsp_ch.valid     = rsp_vld_ff;
   assign rsp_ch.client_id = rsp_client_ff;
   assign rsp_ch.bind_tag  = rsp_tag_ff;
   assign rsp_ch.last      = rsp_last_ff;

   // ---------------- assertions ----------------
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_w))
      else $error("more than one scan token in the cell chain");

   a_one_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_w))
      else $error("more than one cell reports a hit");

   a_token_source: assert property (@(posedge clock) disable iff (reset)
      $rose(tok_w[0]) |-> $past(state_ff) == ST_EVAL)
      else $error("token entered the chain outside of event evaluation");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_vld_ff && (cnt_ff <= CNT_W'(MAX_RESULTS)))
      else $error("pending result left behind at end of scan");

endmodule

`default_nettype wire

// File: hw/rtl/kcm_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module kcm_cell #(
   parameter int CHORD_KEYS = kcm_pkg::CHORD_KEYS_DEF,
   parameter int IDX        = 0
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          advance,
   input  logic                                          tok_i,
   input  logic [CHORD_KEYS-1:0][kcm_pkg::KEY_W-1:0]     held_i,
   input  kcm_pkg::bwr_type                              wr,
   output logic                                          tok_o,
   output logic [CHORD_KEYS-1:0][kcm_pkg::KEY_W-1:0]     held_o,
   output logic                                          hit_o,
   output logic [kcm_pkg::CLIENT_W-1:0]                  owner_o,
   output logic [kcm_pkg::TAG_W-1:0]                     tag_o
);
   import kcm_pkg::*;

   logic                                tok_ff;
   logic [CHORD_KEYS-1:0][KEY_W-1:0]    held_ff;
   logic [CHORD_KEYS-1:0][KEY_W-1:0]    key_ff;
   logic [CLIENT_W-1:0]                 owner_ff;
   logic [TAG_W-1:0]                    tag_ff;
   logic                                valid_ff;
   logic                                sel;
   logic                                all_found;

   assign sel = wr.en && (int'(wr.entry) == IDX);

   // token and held snapshot move one cell per advance
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         held_ff <= held_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (sel) begin
         valid_ff <= wr.enable;
      end
   end

   always_ff @(posedge clock) begin
      if (sel) begin
         owner_ff <= wr.client;
         tag_ff   <= wr.tag;
         for (int i = 0; i < CHORD_KEYS; i++) begin
            if (int'(wr.pos) == i) begin
               key_ff[i] <= wr.key;
            end
         end
      end
   end

   // every bound key must appear in some held slot
   always_comb begin
      logic any;
      all_found = 1'b1;
      for (int k = 0; k < CHORD_KEYS; k++) begin
         any = 1'b0;
         for (int j = 0; j < CHORD_KEYS; j++) begin
            any = any | (held_ff[j] == key_ff[k]);
         end
         all_found = all_found & any;
      end
   end

   assign tok_o   = tok_ff;
   assign held_o  = held_ff;
   assign hit_o   = tok_ff && valid_ff && all_found;
   assign owner_o = hit_o ? owner_ff : '0;
   assign tag_o   = hit_o ? tag_ff : '0;

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import kcm_pkg::*;

   localparam int CHORDS      = CHORD_KEYS_DEF;
   localparam int ENTRIES     = BIND_ENTRIES_DEF;
   localparam int BOARDS      = KEYBOARDS_DEF;
   localparam int EVENT_ITEMS = 260;
   localparam int TAIL_CYCLES = 4 * (ENTRIES + 3);
   localparam int CYCLE_LIMIT = 1000000;

   localparam logic [KEY_W-1:0] KEY_A   = 10'h001;
   localparam logic [KEY_W-1:0] KEY_B   = 10'h2AA;
   localparam logic [KEY_W-1:0] KEY_C   = 10'h155;
   localparam logic [KEY_W-1:0] KEY_D   = 10'h200;
   localparam logic [KEY_W-1:0] KEY_TOP = 10'h3FF;
   localparam logic [KEY_W-1:0] KEY_POOL [5] = '{KEY_A, KEY_B, KEY_C, KEY_D, KEY_TOP};

   localparam logic [KVAL_W-1:0]  KV_REPEAT = 2'd2;
   localparam logic [KVAL_W-1:0]  KV_SPARE  = 2'd3;
   localparam logic [ETYPE_W-1:0] EV_SYN    = 5'd0;
   localparam logic [ETYPE_W-1:0] EV_TOP    = 5'd31;

   typedef struct packed {
      logic [CLIENT_W-1:0] client;
      logic [TAG_W-1:0]    tag;
      logic                last;
   } match_type;

   // Tracks held keys and bindings, and queues the chord matches each event yields.
   class chord_tracker;
      logic [KEY_W-1:0]    held  [BOARDS][CHORDS];
      logic [KEY_W-1:0]    chord [ENTRIES][CHORDS];
      logic                on    [ENTRIES];
      logic [CLIENT_W-1:0] owner [ENTRIES];
      logic [TAG_W-1:0]    tag   [ENTRIES];
      match_type           due [$];
      int errors;
      int checked;
      int scanned;
      int largest;
      int capped;

      function new();
         foreach (held[d, k]) held[d][k] = KEY_EMPTY;
         foreach (chord[e, k]) chord[e][k] = KEY_EMPTY;
         foreach (on[e]) begin
            on[e] = 1'b0;
            owner[e] = '0;
            tag[e] = '0;
         end
         errors = 0;
         checked = 0;
         scanned = 0;
         largest = 0;
         capped = 0;
      endfunction

      function int slot_of(int dev, logic [KEY_W-1:0] code);
         for (int k = 0; k < CHORDS; k++)
            if (held[dev][k] == code) return k;
         return -1;
      endfunction

      function bit chord_held(int dev, int e);
         for (int k = 0; k < CHORDS; k++)
            if (slot_of(dev, chord[e][k]) < 0) return 1'b0;
         return 1'b1;
      endfunction

      function void apply_item(kcm_req_type it);
         int dev;
         int k;
         int n;
         int hits [MAX_RESULTS];
         match_type m;
         if (it.op == OP_BIND) begin
            if (it.bind_entry < ENTRIES && it.bind_pos < CHORDS) begin
               chord[it.bind_entry][it.bind_pos] = it.key_code;
               owner[it.bind_entry] = it.bind_client;
               tag[it.bind_entry] = it.bind_tag_in;
               on[it.bind_entry] = it.bind_enable;
            end
            return;
         end
         dev = int'(it.device_id);
         if (dev >= BOARDS || it.event_type != EV_KEY ||
             (it.key_value != KV_RELEASE && it.key_value != KV_PRESS))
            return;
         k = slot_of(dev, it.key_code);
         if (it.key_value == KV_RELEASE) begin
            if (k >= 0) held[dev][k] = KEY_EMPTY;
         end else begin
            // a held key, or code zero while a slot is free, is ignored outright
            if (k >= 0) return;
            k = slot_of(dev, KEY_EMPTY);
            if (k >= 0) held[dev][k] = it.key_code;
         end
         scanned++;
         n = 0;
         for (int e = 0; e < ENTRIES && n < MAX_RESULTS; e++)
            if (on[e] && chord_held(dev, e)) begin
               hits[n] = e;
               n++;
            end
         for (int i = 0; i < n; i++) begin
            m.client = owner[hits[i]];
            m.tag = tag[hits[i]];
            m.last = (i == n - 1);
            due.push_back(m);
         end
         if (n > largest) largest = n;
         if (n == MAX_RESULTS) capped++;
      endfunction

      function void check_match(logic [CLIENT_W-1:0] client, logic [TAG_W-1:0] btag,
                                logic last);
         match_type m;
         checked++;
         if (due.size() == 0) begin
            errors++;
            $display("%0t: unexpected match transfer: client_id %0d bind_tag 0x%04h last %0b",
                     $time, client, btag, last);
            return;
         end
         m = due.pop_front();
         if (client !== m.client) begin
            errors++;
            $display("%0t: client_id expected %0d, got %0d", $time, m.client, client);
         end
         if (btag !== m.tag) begin
            errors++;
            $display("%0t: bind_tag expected 0x%04h, got 0x%04h", $time, m.tag, btag);
         end
         if (last !== m.last) begin
            errors++;
            $display("%0t: last expected %0b, got %0b", $time, m.last, last);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   burst_left = 1;
   int   items_sent = 0;
   chord_tracker tracker;

   kcm_req_if req_ch ();
   kcm_rsp_if rsp_ch ();

   key_chord_matcher dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("key_chord_matcher test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         tracker.check_match(rsp_ch.client_id, rsp_ch.bind_tag, rsp_ch.last);
   end

   // Receiver: switch between always ready, coin flip and long stalls.
   initial begin
      int mode;
      int mode_left;
      mode = 0;
      mode_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(64, 256);
         end
         mode_left--;
         case (mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
            default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   function automatic kcm_req_type key_event(logic [DEV_W-1:0] dev, logic [KVAL_W-1:0] kval,
                                             logic [KEY_W-1:0] code, logic [ETYPE_W-1:0] etype);
      logic [63:0] r;
      kcm_req_type it;
      r = {$urandom, $urandom};
      it = r[$bits(kcm_req_type)-1:0];
      it.op = OP_EVENT;
      it.device_id = dev;
      it.event_type = etype;
      it.key_code = code;
      it.key_value = kval;
      return it;
   endfunction

   function automatic kcm_req_type bind_write(int e, int p, logic [KEY_W-1:0] code,
                                              logic [CLIENT_W-1:0] client,
                                              logic [TAG_W-1:0] btag, logic en);
      logic [63:0] r;
      kcm_req_type it;
      r = {$urandom, $urandom};
      it = r[$bits(kcm_req_type)-1:0];
      it.op = OP_BIND;
      it.bind_entry = e[ENTRY_W-1:0];
      it.bind_pos = p[POS_W-1:0];
      it.key_code = code;
      it.bind_client = client;
      it.bind_tag_in = btag;
      it.bind_enable = en;
      return it;
   endfunction

   function automatic logic [KEY_W-1:0] pool_key();
      return KEY_POOL[$urandom_range(0, 4)];
   endfunction

   function automatic logic [KEY_W-1:0] chord_key();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) return KEY_EMPTY;
      if (pick < 9) return pool_key();
      return KEY_W'($urandom_range(1, 1023));
   endfunction

   // Hold the item until its transfer, then note it; end the burst with a gap.
   task automatic send_item(input kcm_req_type it);
      req_ch.valid       <= 1'b1;
      req_ch.op          <= it.op;
      req_ch.device_id   <= it.device_id;
      req_ch.event_type  <= it.event_type;
      req_ch.key_code    <= it.key_code;
      req_ch.key_value   <= it.key_value;
      req_ch.bind_entry  <= it.bind_entry;
      req_ch.bind_pos    <= it.bind_pos;
      req_ch.bind_client <= it.bind_client;
      req_ch.bind_tag_in <= it.bind_tag_in;
      req_ch.bind_enable <= it.bind_enable;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      tracker.apply_item(it);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
   endtask

   task automatic write_chord(input int e, input logic [CLIENT_W-1:0] client,
                              input logic [TAG_W-1:0] btag, input logic en, input bit a_only);
      for (int p = 0; p < CHORDS; p++)
         send_item(bind_write(e, p, a_only ? ($urandom_range(0, 1) ? KEY_A : KEY_EMPTY)
                                           : chord_key(),
                              client, btag, (p == CHORDS - 1) ? en : 1'b0));
   endtask

   initial begin
      int pick;
      int dev;
      int n;
      logic [KEY_W-1:0]   code;
      logic [ETYPE_W-1:0] etype;

      tracker = new();
      req_ch.valid       <= 1'b0;
      req_ch.op          <= OP_EVENT;
      req_ch.device_id   <= '0;
      req_ch.event_type  <= '0;
      req_ch.key_code    <= '0;
      req_ch.key_value   <= '0;
      req_ch.bind_entry  <= '0;
      req_ch.bind_pos    <= '0;
      req_ch.bind_client <= '0;
      req_ch.bind_tag_in <= '0;
      req_ch.bind_enable <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, then two chords at the field extremes
      send_item(key_event(0, KV_PRESS, KEY_A, EV_KEY));
      for (int p = 0; p < CHORDS; p++)
         send_item(bind_write(0, p, KEY_EMPTY, '0, '0, p == CHORDS - 1));
      send_item(bind_write(ENTRIES - 1, 0, KEY_TOP, '1, '1, 1'b0));
      send_item(bind_write(ENTRIES - 1, 1, KEY_A, '1, '1, 1'b0));
      send_item(bind_write(ENTRIES - 1, 2, KEY_EMPTY, '1, '1, 1'b0));
      send_item(bind_write(ENTRIES - 1, 3, KEY_EMPTY, '1, '1, 1'b1));
      send_item(key_event(3, KV_PRESS, KEY_TOP, EV_KEY));
      send_item(key_event(3, KV_PRESS, KEY_A, EV_KEY));
      send_item(key_event(3, KV_PRESS, KEY_A, EV_KEY));       // already held
      send_item(key_event(3, KV_REPEAT, KEY_A, EV_KEY));
      send_item(key_event(3, KV_SPARE, KEY_A, EV_KEY));
      send_item(key_event(3, KV_PRESS, KEY_B, EV_SYN));
      send_item(key_event(3, KV_PRESS, KEY_B, EV_TOP));
      send_item(key_event(3, KV_PRESS, KEY_EMPTY, EV_KEY));   // zero with a free slot
      send_item(key_event(3, KV_PRESS, KEY_B, EV_KEY));
      send_item(key_event(3, KV_PRESS, KEY_C, EV_KEY));       // row now full
      send_item(key_event(3, KV_PRESS, KEY_D, EV_KEY));       // dropped, still scans
      send_item(key_event(3, KV_PRESS, KEY_EMPTY, EV_KEY));   // zero on a full row
      send_item(key_event(3, KV_RELEASE, KEY_D, EV_KEY));     // not held
      send_item(key_event(3, KV_RELEASE, KEY_EMPTY, EV_KEY));
      send_item(key_event(3, KV_RELEASE, KEY_TOP, EV_KEY));
      send_item(bind_write(ENTRIES - 1, 0, KEY_TOP, '1, '1, 1'b0));

      // fill every entry with chords of KEY_A and blanks, so one press hits the cap
      for (int e = 0; e < ENTRIES; e++)
         write_chord(e, CLIENT_W'($urandom_range(0, 7)), TAG_W'($urandom), 1'b1, 1'b1);
      send_item(key_event(1, KV_PRESS, KEY_A, EV_KEY));
      send_item(key_event(1, KV_RELEASE, KEY_A, EV_KEY));

      while (items_sent < EVENT_ITEMS) begin
         pick = $urandom_range(0, 99);
         dev = $urandom_range(0, BOARDS - 1);
         if (pick < 12) begin
            write_chord($urandom_range(0, ENTRIES - 1), CLIENT_W'($urandom_range(0, 7)),
                        TAG_W'($urandom), $urandom_range(0, 99) < 85, 1'b0);
         end else if (pick < 72) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               send_item(key_event(dev[DEV_W-1:0], KV_PRESS, pool_key(), EV_KEY));
            end else if (pick < 80) begin
               code = tracker.held[dev][$urandom_range(0, CHORDS - 1)];
               if (code == KEY_EMPTY) code = pool_key();
               send_item(key_event(dev[DEV_W-1:0], KV_RELEASE, code, EV_KEY));
            end else if (pick < 88) begin
               send_item(key_event(dev[DEV_W-1:0], KV_RELEASE,
                                   KEY_W'($urandom_range(0, 1023)), EV_KEY));
            end else if (pick < 94) begin
               send_item(key_event(dev[DEV_W-1:0], KV_PRESS,
                                   KEY_W'($urandom_range(1, 1023)), EV_KEY));
            end else begin
               send_item(key_event(dev[DEV_W-1:0],
                                   $urandom_range(0, 1) ? KV_PRESS : KV_RELEASE,
                                   KEY_EMPTY, EV_KEY));
            end
         end else if (pick < 80) begin
            // broken sequence: a few stray slot writes, entry left disabled
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
               send_item(bind_write($urandom_range(0, ENTRIES - 1), $urandom_range(0, 3),
                                    chord_key(), CLIENT_W'($urandom_range(0, 7)),
                                    TAG_W'($urandom), 1'b0));
         end else if (pick < 90) begin
            etype = ETYPE_W'($urandom_range(0, (1 << ETYPE_W) - 1));
            if (etype == EV_KEY) etype = EV_TOP;
            send_item(key_event(dev[DEV_W-1:0], KVAL_W'($urandom_range(0, 3)), pool_key(),
                                etype));
         end else begin
            send_item(key_event(dev[DEV_W-1:0], $urandom_range(0, 1) ? KV_REPEAT : KV_SPARE,
                                KEY_W'($urandom_range(0, 1023)), EV_KEY));
         end
      end

      req_ch.valid <= 1'b0;
      while (tracker.due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d request transfers, %0d scanning key events, %0d match transfers",
               items_sent, tracker.scanned, tracker.checked);
      $display("Largest match burst %0d, %0d events reached the result cap",
               tracker.largest, tracker.capped);
      if (tracker.errors == 0) begin
         $display("key_chord_matcher test passed");
      end else begin
         $display("key_chord_matcher test failed");
      end
      $finish;
   end

endmodule
